### rtl/deq_pkg.sv
// Shared constants and control types for the double-ended queue.
// No dependencies; imported by every module of the block.
package deq_pkg;

   localparam int DEQ_DEPTH     = 16;
   localparam int DEQ_WORD_BITS = 32;
   localparam int REQ_BITS      = 3;
   localparam int STATUS_BITS   = 2;

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // per-chain cell command
   typedef struct packed {
      logic shift_up;    // cell i takes cell i-1, cell 0 takes the new word
      logic shift_down;  // cell i takes cell i+1
      logic load;        // cell at index == count takes the new word
   } deq_cmd_type;

   typedef struct packed {
      deq_cmd_type                cmd_fwd;   // chain with the front at cell 0
      deq_cmd_type                cmd_rev;   // chain with the rear at cell 0
      logic                       take_front;
      logic                       take_back;
      logic [STATUS_BITS-1:0]     status;
   } deq_ctl_type;

endpackage

### rtl/deq_cell.sv
// One storage cell of a queue chain: holds a word and moves it to or from
// its neighbors as commanded. Depends on deq_pkg.
module deq_cell
   import deq_pkg::*;
#(
   parameter int WORD_BITS = DEQ_WORD_BITS,
   parameter int CNT_BITS  = 5,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  deq_cmd_type          cmd,
   input  logic [CNT_BITS-1:0]  count,
   input  logic [WORD_BITS-1:0] word,
   input  logic [WORD_BITS-1:0] from_lower,
   input  logic [WORD_BITS-1:0] from_upper,
   output logic [WORD_BITS-1:0] data_q,
   output logic [WORD_BITS-1:0] data_next
);

   logic [WORD_BITS-1:0] data_ff;
   logic [WORD_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         data_in = from_lower;
      end else if (cmd.shift_down) begin
         data_in = from_upper;
      end else if (cmd.load && (count == CNT_BITS'(INDEX))) begin
         data_in = word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q    = data_ff;
   assign data_next = data_in;

endmodule

### rtl/deq_ctrl.sv
// Request decoder and entry counter: checks full/empty, picks the cell
// commands for both chains and keeps the count. Depends on deq_pkg.
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH    = DEQ_DEPTH,
   parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [REQ_BITS-1:0] req_code,
   output deq_ctl_type         ctl,
   output logic [CNT_BITS-1:0] count_q,
   output logic [CNT_BITS-1:0] count_next
);

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                full;
   logic                empty;

   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      ctl      = '0;
      count_in = count_ff;
      if (accept) begin
         case (req_code)
            REQ_PUSH_BACK: begin
               if (full) begin
                  ctl.status = ST_FULL;
               end else begin
                  ctl.cmd_fwd.load     = 1'b1;
                  ctl.cmd_rev.shift_up = 1'b1;
                  count_in             = count_ff + 1'b1;
               end
            end
            REQ_PUSH_FRONT: begin
               if (full) begin
                  ctl.status = ST_FULL;
               end else begin
                  ctl.cmd_fwd.shift_up = 1'b1;
                  ctl.cmd_rev.load     = 1'b1;
                  count_in             = count_ff + 1'b1;
               end
            end
            REQ_POP_FRONT: begin
               if (empty) begin
                  ctl.status = ST_EMPTY;
               end else begin
                  ctl.cmd_fwd.shift_down = 1'b1;
                  ctl.take_front         = 1'b1;
                  count_in               = count_ff - 1'b1;
               end
            end
            REQ_POP_BACK: begin
               if (empty) begin
                  ctl.status = ST_EMPTY;
               end else begin
                  ctl.cmd_rev.shift_down = 1'b1;
                  ctl.take_back          = 1'b1;
                  count_in               = count_ff - 1'b1;
               end
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // unknown codes leave the queue alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_q    = count_ff;
   assign count_next = count_in;

endmodule

### rtl/double_ended_queue_top.sv
// Double-ended queue top level: two chains of deq_cell plus deq_ctrl and the
// result register. Depends on deq_pkg, deq_cell and deq_ctrl.
//
// A request is taken at every clock edge where start is high; busy is always
// low, so one request per cycle is sustained. Each request gives exactly one
// item on the rsp_ ports, with rsp_strobe high, in the cycle right after the
// request, when the result register that drives them has loaded alongside the
// cells of both chains. The receiver cannot stall, so each item must
// be captured in its strobe cycle. The words live twice: one chain keeps the
// front in cell 0, the other keeps the rear in cell 0, so every push or pop that
// is not refused is a shift or a load of a single cell, and front and rear are
// always at fixed cells. No clearing pass after reset; the queue is empty at once.
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int DEPTH     = DEQ_DEPTH,
   parameter int WORD_BITS = DEQ_WORD_BITS,
   parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [REQ_BITS-1:0]           req_type,
   input  logic signed [WORD_BITS-1:0]   req_push_value,
   output logic                          rsp_strobe,
   output logic signed [WORD_BITS-1:0]   rsp_popped_value,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic signed [WORD_BITS-1:0]   rsp_front_value,
   output logic signed [WORD_BITS-1:0]   rsp_rear_value,
   output logic [CNT_BITS-1:0]           rsp_occupancy
);

   logic                 accept;
   deq_ctl_type          ctl;
   logic [CNT_BITS-1:0]  count_q;
   logic [CNT_BITS-1:0]  count_next;
   logic [WORD_BITS-1:0] word;

   logic [WORD_BITS-1:0] fwd_q    [DEPTH];
   logic [WORD_BITS-1:0] fwd_next [DEPTH];
   logic [WORD_BITS-1:0] fwd_lo   [DEPTH];
   logic [WORD_BITS-1:0] fwd_hi   [DEPTH];
   logic [WORD_BITS-1:0] rev_q    [DEPTH];
   logic [WORD_BITS-1:0] rev_next [DEPTH];
   logic [WORD_BITS-1:0] rev_lo   [DEPTH];
   logic [WORD_BITS-1:0] rev_hi   [DEPTH];

   logic                   strobe_ff;
   logic [WORD_BITS-1:0]   popped_ff, popped_in;
   logic [STATUS_BITS-1:0] status_ff;
   logic [WORD_BITS-1:0]   front_ff, front_in;
   logic [WORD_BITS-1:0]   rear_ff, rear_in;
   logic [CNT_BITS-1:0]    occ_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign word   = req_push_value;

   deq_ctrl #(
      .DEPTH    (DEPTH),
      .CNT_BITS (CNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_code   (req_type),
      .ctl        (ctl),
      .count_q    (count_q),
      .count_next (count_next)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign fwd_lo[i] = word;
         assign rev_lo[i] = word;
      end else begin : g_mid_lo
         assign fwd_lo[i] = fwd_q[i-1];
         assign rev_lo[i] = rev_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign fwd_hi[i] = fwd_q[i];
         assign rev_hi[i] = rev_q[i];
      end else begin : g_mid_hi
         assign fwd_hi[i] = fwd_q[i+1];
         assign rev_hi[i] = rev_q[i+1];
      end

      deq_cell #(
         .WORD_BITS (WORD_BITS),
         .CNT_BITS  (CNT_BITS),
         .INDEX     (i)
      ) u_fwd (
         .clock      (clock),
         .cmd        (ctl.cmd_fwd),
         .count      (count_q),
         .word       (word),
         .from_lower (fwd_lo[i]),
         .from_upper (fwd_hi[i]),
         .data_q     (fwd_q[i]),
         .data_next  (fwd_next[i])
      );

      deq_cell #(
         .WORD_BITS (WORD_BITS),
         .CNT_BITS  (CNT_BITS),
         .INDEX     (i)
      ) u_rev (
         .clock      (clock),
         .cmd        (ctl.cmd_rev),
         .count      (count_q),
         .word       (word),
         .from_lower (rev_lo[i]),
         .from_upper (rev_hi[i]),
         .data_q     (rev_q[i]),
         .data_next  (rev_next[i])
      );
   end

   always_comb begin
      popped_in = '0;
      if (ctl.take_front) begin
         popped_in = fwd_q[0];
      end else if (ctl.take_back) begin
         popped_in = rev_q[0];
      end
      front_in = '0;
      rear_in  = '0;
      if (count_next != '0) begin
         front_in = fwd_next[0];
         rear_in  = rev_next[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped_in;
         status_ff <= ctl.status;
         front_ff  <= front_in;
         rear_ff   <= rear_in;
         occ_ff    <= count_next;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_front_value  = front_ff;
   assign rsp_rear_value   = rear_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

### rtl/deq_checker.sv
// Port-level checks for double_ended_queue_top, attached by the bind below.
// Depends on deq_pkg.
module deq_checker
   import deq_pkg::*;
#(
   parameter int DEPTH     = DEQ_DEPTH,
   parameter int WORD_BITS = DEQ_WORD_BITS,
   parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [REQ_BITS-1:0]         req_type,
   input logic signed [WORD_BITS-1:0] req_push_value,
   input logic                        rsp_strobe,
   input logic signed [WORD_BITS-1:0] rsp_popped_value,
   input logic [STATUS_BITS-1:0]      rsp_status,
   input logic signed [WORD_BITS-1:0] rsp_front_value,
   input logic signed [WORD_BITS-1:0] rsp_rear_value,
   input logic [CNT_BITS-1:0]         rsp_occupancy
);

   // every accepted item yields one result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("missing result after accepted item");

   // no result without an accepted item in the previous cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset))
      else $error("result without accepted item");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |->
         (rsp_occupancy == CNT_BITS'(DEPTH) && rsp_popped_value == '0))
      else $error("full refusal with queue not full");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |->
         (rsp_occupancy == '0 && rsp_popped_value == '0))
      else $error("empty refusal with queue not empty");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_occupancy == '0) |->
         (rsp_front_value == '0 && rsp_rear_value == '0))
      else $error("empty queue reports nonzero ends");

endmodule

bind double_ended_queue_top deq_checker #(
   .DEPTH     (DEPTH),
   .WORD_BITS (WORD_BITS),
   .CNT_BITS  (CNT_BITS)
) u_deq_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_top: random push/pop/clear traffic
// checked against an in-bench deque predictor. Depends on deq_pkg and the RTL.
module testbench;
   import deq_pkg::*;

   localparam logic [REQ_BITS-1:0] REQ_UNKNOWN_FIRST = 3'd5;
   localparam logic [REQ_BITS-1:0] REQ_UNKNOWN_MID   = 3'd6;
   localparam logic [REQ_BITS-1:0] REQ_UNKNOWN_LAST  = 3'd7;
   localparam int STUCK_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct {
      logic [REQ_BITS-1:0]        kind;
      logic signed [31:0]         word;
      bit                         drain_first;  // hold off until all results are back
   } deq_item_type;

   typedef struct {
      logic signed [31:0]         popped;
      logic [STATUS_BITS-1:0]     status;
      logic signed [31:0]         front;
      logic signed [31:0]         rear;
      logic [4:0]                 occupancy;
   } deq_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [REQ_BITS-1:0]          req_type = REQ_PUSH_BACK;
   logic signed [31:0]           req_push_value = '0;
   logic                         rsp_strobe;
   logic signed [31:0]           rsp_popped_value;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic signed [31:0]           rsp_front_value;
   logic signed [31:0]           rsp_rear_value;
   logic [4:0]                   rsp_occupancy;

   double_ended_queue_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_front_value  (rsp_front_value),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] ring_words [DEQ_DEPTH];
   int ring_head = 0;
   int ring_tail = 0;
   int ring_count = 0;

   deq_item_type   pending_items [$];
   deq_result_type expected_results [$];
   int sent_n = 0;
   int got_n = 0;
   int mismatches = 0;
   int stuck_cycles = 0;

   function automatic deq_result_type predict_deque(logic [REQ_BITS-1:0] kind,
                                                    logic signed [31:0] word);
      deq_result_type r;
      r.popped = '0;
      r.status = ST_DONE;
      r.front = '0;
      r.rear = '0;
      case (kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            if (ring_count >= DEQ_DEPTH) begin
               r.status = ST_FULL;
            end else if (kind == REQ_PUSH_BACK) begin
               ring_words[ring_tail] = word;
               ring_tail = (ring_tail + 1) % DEQ_DEPTH;
               ring_count++;
            end else begin
               ring_head = (ring_head + DEQ_DEPTH - 1) % DEQ_DEPTH;
               ring_words[ring_head] = word;
               ring_count++;
            end
         end
         REQ_POP_FRONT: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped = ring_words[ring_head];
               ring_head = (ring_head + 1) % DEQ_DEPTH;
               ring_count--;
            end
         end
         REQ_POP_BACK: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               ring_tail = (ring_tail + DEQ_DEPTH - 1) % DEQ_DEPTH;
               r.popped = ring_words[ring_tail];
               ring_count--;
            end
         end
         REQ_CLEAR: begin
            ring_head = 0;
            ring_tail = 0;
            ring_count = 0;
         end
         default: ;  // unknown codes leave the queue alone
      endcase
      if (ring_count != 0) begin
         r.front = ring_words[ring_head];
         r.rear = ring_words[(ring_tail + DEQ_DEPTH - 1) % DEQ_DEPTH];
      end
      r.occupancy = ring_count[4:0];
      return r;
   endfunction

   // driver: bursts of items separated by random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      deq_item_type it;
      bit drive_now;
      if (reset) begin
         start <= 1'b0;
      end else begin
         drive_now = 1'b0;
         if (start && !busy) begin
            sent_n = sent_n + 1;
         end
         if (start && busy) begin
            drive_now = 1'b1;  // item not taken yet, keep it up
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0 &&
                      !(pending_items[0].drain_first && got_n != sent_n)) begin
            it = pending_items[0];
            pending_items.delete(0);
            drive_now = 1'b1;
            req_type <= it.kind;
            req_push_value <= it.word;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 23);
               case ($urandom_range(0, 9))
                  0, 1, 2: gap_left = 0;
                  9:       gap_left = $urandom_range(5, 20);
                  default: gap_left = $urandom_range(1, 3);
               endcase
            end
         end
         start <= drive_now;
      end
   end

   // monitor: predicts on each accepted item, checks each result item
   always @(posedge clock) begin
      deq_result_type want;
      bit progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_strobe) begin
            progress = 1'b1;
            got_n <= got_n + 1;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: popped %0d status %0d", rsp_popped_value,
                           rsp_status);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_popped_value !== want.popped || rsp_status !== want.status ||
                   rsp_front_value !== want.front || rsp_rear_value !== want.rear ||
                   rsp_occupancy !== want.occupancy) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: popped %0d/%0d status %0d/%0d front %0d/%0d",
                              want.popped, rsp_popped_value, want.status, rsp_status,
                              want.front, rsp_front_value);
                     $display("  rear %0d/%0d occupancy %0d/%0d (expected/actual)",
                              want.rear, rsp_rear_value, want.occupancy, rsp_occupancy);
                  end
               end
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            expected_results.insert(expected_results.size(),
                                    predict_deque(req_type, req_push_value));
         end
         stuck_cycles = progress ? 0 : stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("double_ended_queue_top test failed");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_item(logic [REQ_BITS-1:0] kind, logic signed [31:0] word,
                                    bit drain_first = 1'b0);
      deq_item_type it;
      it.kind = kind;
      it.word = word;
      it.drain_first = drain_first;
      pending_items.insert(pending_items.size(), it);
   endfunction

   initial begin
      int counted;
      int len;
      bit hold;
      logic [REQ_BITS-1:0] kind;

      // directed: empty pops, front push on empty, extreme words, unknown codes
      add_item(REQ_POP_FRONT, 32'sh1234_5678);
      add_item(REQ_POP_BACK, -32'sd1);
      add_item(REQ_PUSH_FRONT, 32'sh7fff_ffff);
      add_item(REQ_POP_BACK, '0);
      add_item(REQ_POP_BACK, '0);
      add_item(REQ_PUSH_BACK, 32'sh8000_0000);
      add_item(REQ_PUSH_FRONT, '0);
      add_item(REQ_PUSH_BACK, -32'sd1);
      add_item(REQ_PUSH_FRONT, 32'sh5555_aaaa);
      add_item(REQ_POP_FRONT, '0);
      add_item(REQ_POP_BACK, '0);
      add_item(REQ_UNKNOWN_FIRST, 32'sh0f0f_0f0f);
      add_item(REQ_UNKNOWN_MID, 32'sh7fff_ffff);
      add_item(REQ_UNKNOWN_LAST, -32'sd1);
      add_item(REQ_CLEAR, 32'sh1111_1111);
      add_item(REQ_POP_FRONT, '0);
      add_item(REQ_PUSH_BACK, 32'sh0000_0001);
      add_item(REQ_POP_FRONT, '0);
      add_item(REQ_POP_FRONT, '0);
      add_item(REQ_CLEAR, '0);

      // random: fill runs, drain runs, mixed runs and a little noise
      counted = 0;
      hold = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = $urandom_range(10, 22);
               repeat (len) begin
                  if ($urandom_range(0, 9) == 0)
                     kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
                  else
                     kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                  add_item(kind, pick_word(), hold);
                  hold = 1'b0;
                  counted++;
               end
            end
            3, 4, 5: begin
               len = $urandom_range(10, 22);
               repeat (len) begin
                  if ($urandom_range(0, 9) == 0)
                     kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                  else
                     kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
                  add_item(kind, pick_word(), hold);
                  hold = 1'b0;
                  counted++;
               end
            end
            6, 7, 8: begin
               len = $urandom_range(5, 20);
               repeat (len) begin
                  kind = REQ_BITS'($urandom_range(REQ_PUSH_BACK, REQ_POP_BACK));
                  add_item(kind, pick_word(), hold);
                  hold = 1'b0;
                  counted++;
               end
            end
            default: begin
               if ($urandom_range(0, 1)) begin
                  add_item(REQ_CLEAR, pick_word(), hold);
                  counted++;
               end else begin
                  kind = REQ_BITS'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
                  add_item(kind, pick_word(), hold);
               end
               hold = 1'b0;
            end
         endcase
         // now and then wait for the queue of results to empty before the next run
         if ($urandom_range(0, 7) == 0)
            hold = 1'b1;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(negedge clock);
         if (pending_items.size() == 0 && !start && expected_results.size() == 0)
            break;
      end
      repeat (4) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("double_ended_queue_top test passed");
      end else begin
         $display("double_ended_queue_top test failed");
      end
      $finish;
   end

endmodule
